FILE: rtl/srx_pkg.sv
// Package: sizes, control and status types and helpers for the scrypt ROMix core.
`default_nettype none
package srx_pkg;
  localparam int R_BLOCKS = 1;
  localparam int MAX_COST_LOG2 = 10;
  localparam int BLK_WORDS = 32 * R_BLOCKS;
  localparam int SUB_COUNT = 2 * R_BLOCKS;
  localparam int WW = $clog2(BLK_WORDS);
  localparam int PAD_AW = MAX_COST_LOG2 + WW;
  localparam int PAD_DEPTH = (1 << MAX_COST_LOG2) * BLK_WORDS;
  localparam int RW = MAX_COST_LOG2 + 1;
  localparam logic [3:0] COST_RESET = 4'd10;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
  } salsa_ctl_t;

  typedef struct packed {
    logic done;
  } salsa_sts_t;

  function automatic word_t rol(input word_t v, input int c);
    rol = (v << c) | (v >> (32 - c));
  endfunction
endpackage
`default_nettype wire

FILE: rtl/scrypt_romix_core.sv
// Top level: load, ROMix sequencer with scratchpad, and result output.
//  channel | signals                         | dir
//  cfg     | cfg_valid cfg_ready cfg_data[3:0] | in
//  input   | in_valid in_ready data_word     | in
//  output  | out_valid out_ready result_word final_word | out
// Per block: load, 2N BlockMix calls, then 32R output beats. Each call runs 2R Salsa
// passes of 32 quarter-round steps on the shared unit, after a scratchpad copy in the first
// half or a scratchpad read and xor in the second.
// Reset is synchronous; no clearing pass.
// Output stalls hold the current beat; no input is taken until all 32R beats go.
`default_nettype none
module scrypt_romix_core import srx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_word,
  output logic             final_word
);
  localparam logic [2:0] S_LOAD = 3'd0, S_COPY = 3'd1, S_XOR = 3'd2,
                         S_PREP = 3'd3, S_RUN = 3'd4, S_STORE = 3'd5, S_OUT = 3'd6;

  logic [2:0] state;
  logic [3:0] cost;
  logic [3:0] lg;
  word_t blk [BLK_WORDS];
  word_t y [BLK_WORDS];
  word_t x [16];
  word_t xo [16];
  word_t pad [PAD_DEPTH];
  word_t pad_q;
  logic [WW:0] wc;
  logic [RW-1:0] rc;
  logic pass2;
  logic [MAX_COST_LOG2-1:0] idx;
  logic [$clog2(SUB_COUNT+1)-1:0] sub;
  logic rd_pend;
  logic [WW-1:0] rd_w;
  salsa_ctl_t sctl;
  salsa_sts_t ssts;
  logic [RW-1:0] n;
  logic [WW:0] pos;

  srx_salsa u_salsa (.clk, .rst, .ctl(sctl), .x_in(x), .sts(ssts), .x_out(xo));

  always_comb begin
    lg = cost;
    if (lg == 4'd0) lg = 4'd1;
    if (lg > 4'(MAX_COST_LOG2)) lg = 4'(MAX_COST_LOG2);
    n = RW'(1) << lg;
    pos = (WW+1)'((32'(sub) / 2 + (32'(sub) % 2) * R_BLOCKS) * 16);
  end

  assign cfg_ready = (state == S_LOAD);
  assign in_ready = (state == S_LOAD);
  assign out_valid = (state == S_OUT);
  assign result_word = blk[wc[WW-1:0]];
  assign final_word = (wc == (WW+1)'(BLK_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) cost <= COST_RESET;
    else if (cfg_valid && cfg_ready) cost <= cfg_data;
  end

  always_ff @(posedge clk) begin
    pad_q <= pad[{idx, wc[WW-1:0]}];
    if (state == S_COPY)
      pad[{rc[MAX_COST_LOG2-1:0], wc[WW-1:0]}] <= blk[wc[WW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      wc <= '0;
      rc <= '0;
      pass2 <= 1'b0;
      sub <= '0;
      rd_pend <= 1'b0;
      sctl.start <= 1'b0;
    end else begin
      sctl.start <= 1'b0;
      rd_pend <= 1'b0;
      unique case (state)
        S_LOAD: if (in_valid) begin
          blk[wc[WW-1:0]] <= data_word;
          if (wc == (WW+1)'(BLK_WORDS - 1)) begin
            wc <= '0; rc <= '0; pass2 <= 1'b0; state <= S_COPY;
          end else wc <= wc + 1'b1;
        end
        S_COPY: begin
          if (wc == (WW+1)'(BLK_WORDS - 1)) begin
            wc <= '0; sub <= '0; state <= S_PREP;
            for (int k = 0; k < 16; k++) x[k] <= blk[(SUB_COUNT-1)*16 + k];
          end else wc <= wc + 1'b1;
        end
        S_XOR: begin
          if (rd_pend) blk[rd_w] <= blk[rd_w] ^ pad_q;
          if (wc < (WW+1)'(BLK_WORDS)) begin
            rd_pend <= 1'b1; rd_w <= wc[WW-1:0]; wc <= wc + 1'b1;
          end else if (!rd_pend) begin
            wc <= '0; sub <= '0; state <= S_PREP;
            for (int k = 0; k < 16; k++) x[k] <= blk[(SUB_COUNT-1)*16 + k];
          end
        end
        S_PREP: begin
          for (int k = 0; k < 16; k++) x[k] <= x[k] ^ blk[32'(sub)*16 + k];
          sctl.start <= 1'b1;
          state <= S_RUN;
        end
        S_RUN: if (ssts.done) begin
          for (int k = 0; k < 16; k++) begin
            x[k] <= xo[k];
            y[32'(pos) + k] <= xo[k];
          end
          if (32'(sub) == SUB_COUNT - 1) state <= S_STORE;
          else begin sub <= sub + 1'b1; state <= S_PREP; end
        end
        S_STORE: begin
          for (int k = 0; k < BLK_WORDS; k++) blk[k] <= y[k];
          wc <= '0;
          if (rc == n - 1'b1) begin
            rc <= '0;
            if (pass2) state <= S_OUT;
            else begin
              pass2 <= 1'b1; state <= S_XOR;
              idx <= y[(SUB_COUNT-1)*16][MAX_COST_LOG2-1:0] & MAX_COST_LOG2'(n - 1'b1);
            end
          end else begin
            rc <= rc + 1'b1;
            if (pass2) begin
              state <= S_XOR;
              idx <= y[(SUB_COUNT-1)*16][MAX_COST_LOG2-1:0] & MAX_COST_LOG2'(n - 1'b1);
            end else state <= S_COPY;
          end
        end
        S_OUT: if (out_ready) begin
          if (final_word) begin wc <= '0; state <= S_LOAD; end
          else wc <= wc + 1'b1;
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/srx_salsa.sv
// Salsa20/8 core: one quarter-round step per cycle, then the feed-forward add.
`default_nettype none
module srx_salsa import srx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire salsa_ctl_t ctl,
  input  wire word_t      x_in [16],
  output salsa_sts_t      sts,
  output word_t           x_out [16]
);
  word_t s [16];
  word_t b [16];
  logic [4:0] step;
  logic busy;
  logic [3:0] ia, ib, ic, id;
  word_t t1, t2, t3, t4;

  always_comb begin
    unique case (step[2:0])
      3'd0: begin ia = 4'd0;  ib = 4'd4;  ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd5;  ib = 4'd9;  ic = 4'd13; id = 4'd1;  end
      3'd2: begin ia = 4'd10; ib = 4'd14; ic = 4'd2;  id = 4'd6;  end
      3'd3: begin ia = 4'd15; ib = 4'd3;  ic = 4'd7;  id = 4'd11; end
      3'd4: begin ia = 4'd0;  ib = 4'd1;  ic = 4'd2;  id = 4'd3;  end
      3'd5: begin ia = 4'd5;  ib = 4'd6;  ic = 4'd7;  id = 4'd4;  end
      3'd6: begin ia = 4'd10; ib = 4'd11; ic = 4'd8;  id = 4'd9;  end
      default: begin ia = 4'd15; ib = 4'd12; ic = 4'd13; id = 4'd14; end
    endcase
    t1 = s[ib] ^ rol(s[ia] + s[id], 7);
    t2 = s[ic] ^ rol(t1 + s[ia], 9);
    t3 = s[id] ^ rol(t2 + t1, 13);
    t4 = s[ia] ^ rol(t3 + t2, 18);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 5'd31) begin
          busy <= 1'b0;
          sts.done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < 16; k++) begin
        s[k] <= x_in[k];
        b[k] <= x_in[k];
      end
    end else if (busy) begin
      s[ia] <= t4;
      s[ib] <= t1;
      s[ic] <= t2;
      s[id] <= t3;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) x_out[k] = s[k] + b[k];
  end
endmodule
`default_nettype wire

FILE: rtl/srx_checker.sv
// Port-level checker for the scrypt ROMix core, bound to the top level.
`default_nettype none
module srx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        cfg_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result_word,
  input wire logic        final_word
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while emitting");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == in_ready) else $error("config open while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_word))
    else $error("output beat dropped");
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && final_word |=> !out_valid && in_ready)
    else $error("no return to load after last beat");
endmodule
bind scrypt_romix_core srx_checker u_chk (.*);
`default_nettype wire
